[rtl/prb_pkg.sv]
// Shared types and constants for the page range buddy split core.
// No dependencies; every module of the block imports this package.
package prb_pkg;

   // Field widths of the item channels
   localparam int ADDR_W      = 56;
   localparam int FRAME_OUT_W = 44;
   localparam int ORDER_W     = 4;
   localparam int REPEAT_W    = 35;

   // Default configuration of the top level
   localparam int DEF_ORDER_COUNT = 11;
   localparam int DEF_PAGE_BITS   = 12;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_LEN,
      ST_DIFF,
      ST_FORM
   } prb_state_type;

   // Shared adder operations
   typedef enum logic {
      OP_ADD,
      OP_SUB
   } prb_op_type;

   // Block decision from the order unit
   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic               cap_run;
      logic               last;
   } prb_dec_type;

endpackage

[rtl/prb_alu.sv]
// Shared add/subtract unit of the page range buddy split core.
// Depends on prb_pkg for the operation codes.
module prb_alu
   import prb_pkg::*;
#(
   parameter int W = ADDR_W + 1
) (
   input  prb_op_type     op,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic [W-1:0]   res,
   output logic           flag
);

   logic         sub;
   logic [W-1:0] b_eff;
   logic [W:0]   sum;

   // One adder: subtract is a plus inverted b plus one
   always_comb begin
      sub   = (op == OP_SUB);
      b_eff = b ^ {W{sub}};
      sum   = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};
      res   = sum[W-1:0];
      // carry out on add, borrow on subtract
      flag  = sub ? !sum[W] : sum[W];
   end

endmodule

[rtl/prb_order.sv]
// Block order unit: picks the buddy order, step and repeat count at the cursor.
// Depends on prb_pkg for the decision struct and the order width.
module prb_order
   import prb_pkg::*;
#(
   parameter int FW  = 45,
   parameter int CAP = DEF_ORDER_COUNT - 1
) (
   input  logic [FW-1:0] cursor,
   input  logic [FW-1:0] rem,
   output prb_dec_type   dec,
   output logic [FW-1:0] step,
   output logic [FW-1:0] rep_cnt
);

   localparam logic [ORDER_W-1:0] CAP_V = ORDER_W'(CAP);

   logic [ORDER_W-1:0] tz;
   logic               found;
   logic [ORDER_W-1:0] fit;
   logic               hi_any;
   logic [ORDER_W-1:0] order;
   logic               cap_run;

   always_comb begin
      // trailing zeros of the cursor, capped; a zero frame counts as the cap
      tz    = CAP_V;
      found = 1'b0;
      for (int i = 0; i < CAP; i++) begin
         if (!found && cursor[i]) begin
            tz    = ORDER_W'(i);
            found = 1'b1;
         end
      end

      // largest order that still fits below the limit
      hi_any = |(rem >> CAP);
      fit    = '0;
      for (int i = 0; i < CAP; i++) begin
         if (rem[i]) begin
            fit = ORDER_W'(i);
         end
      end
      if (hi_any) begin
         fit = CAP_V;
      end

      order   = (tz < fit) ? tz : fit;
      cap_run = (order == CAP_V);

      // cap-order blocks merge into one run covering all whole cap blocks
      if (cap_run) begin
         rep_cnt = rem >> CAP;
         step    = (rem >> CAP) << CAP;
      end else begin
         rep_cnt = FW'(1);
         step    = FW'(1) << order;
      end

      dec.order   = order;
      dec.cap_run = cap_run;
      dec.last    = (step == rem);
   end

endmodule

[rtl/page_range_buddy_split_core.sv]
// Top level of the page range buddy split core: sequencer, state and result register.
// Depends on prb_pkg, prb_alu and prb_order.
//
//   channel | ports            | direction | moves
//   --------+------------------+-----------+------------------------------------
//   req     | req_valid/ready  | in        | one byte range [start, end)
//   rsp     | rsp_valid/ready  | out       | one block or cap-order run, or none
//
// An item yields N results (1 to 2*ORDER_COUNT-1): the sequencer passes ROUND and LEN,
// then DIFF and FORM for each result. The single shared adder is used twice per result:
// once for the remaining frames, once to advance the cursor.
// Synchronous active-high reset returns to idle with no result pending.
// A stalled result holds the next one in the sequencer; req_ready is high only when idle.
module page_range_buddy_split_core
   import prb_pkg::*;
#(
   parameter int ORDER_COUNT = DEF_ORDER_COUNT,
   parameter int PAGE_BITS   = DEF_PAGE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ADDR_W-1:0]      req_range_start,
   input  logic [ADDR_W-1:0]      req_range_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_has_block,
   output logic [FRAME_OUT_W-1:0] rsp_block_frame,
   output logic [ORDER_W-1:0]     rsp_block_order,
   output logic [REPEAT_W-1:0]    rsp_block_repeat,
   output logic [ADDR_W-1:0]      rsp_freed_bytes,
   output logic                   rsp_last
);

   localparam int CAP = ORDER_COUNT - 1;
   localparam int UW  = ADDR_W + 1;
   localparam int FW  = UW - PAGE_BITS;

   prb_state_type state_ff, state_in;

   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic [FW-1:0]     cursor_ff, cursor_in;
   logic [FW-1:0]     limit_ff, limit_in;
   logic [ADDR_W-1:0] length_ff, length_in;
   logic [FW-1:0]     rem_ff, rem_in;
   logic              empty_ff, empty_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   has_block_ff, has_block_in;
   logic [FRAME_OUT_W-1:0] frame_ff, frame_in;
   logic [ORDER_W-1:0]     order_ff, order_in;
   logic [REPEAT_W-1:0]    repeat_ff, repeat_in;
   logic [ADDR_W-1:0]      freed_ff, freed_in;
   logic                   last_ff, last_in;

   prb_op_type    alu_op;
   logic [UW-1:0] alu_a;
   logic [UW-1:0] alu_b;
   logic [UW-1:0] alu_res;
   logic          alu_flag;

   prb_dec_type   dec;
   logic [FW-1:0] step;
   logic [FW-1:0] rep_cnt;

   logic                      out_free;
   logic [FW+FRAME_OUT_W-1:0] frame_ext;
   logic [FW+REPEAT_W-1:0]    repeat_ext;

   prb_alu #(
      .W (UW)
   ) u_alu (
      .op   (alu_op),
      .a    (alu_a),
      .b    (alu_b),
      .res  (alu_res),
      .flag (alu_flag)
   );

   prb_order #(
      .FW  (FW),
      .CAP (CAP)
   ) u_order (
      .cursor  (cursor_ff),
      .rem     (rem_ff),
      .dec     (dec),
      .step    (step),
      .rep_cnt (rep_cnt)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign frame_ext  = {{FRAME_OUT_W{1'b0}}, cursor_ff};
   assign repeat_ext = {{REPEAT_W{1'b0}}, rep_cnt};

   // Sequencer: next state, adder operands and result loading
   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      cursor_in    = cursor_ff;
      limit_in     = limit_ff;
      length_in    = length_ff;
      rem_in       = rem_ff;
      empty_in     = empty_ff;
      alu_op       = OP_ADD;
      alu_a        = '0;
      alu_b        = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      has_block_in = has_block_ff;
      frame_in     = frame_ff;
      order_in     = order_ff;
      repeat_in    = repeat_ff;
      freed_in     = freed_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               start_in = req_range_start;
               end_in   = req_range_end;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // round the end up to a frame, the start down
            alu_op    = OP_ADD;
            alu_a     = {1'b0, end_ff};
            alu_b     = {{(UW-PAGE_BITS){1'b0}}, {PAGE_BITS{1'b1}}};
            limit_in  = alu_res[UW-1:PAGE_BITS];
            cursor_in = {1'b0, start_ff[ADDR_W-1:PAGE_BITS]};
            state_in  = ST_LEN;
         end
         ST_LEN: begin
            // byte length, zero when the end is below the start
            alu_op    = OP_SUB;
            alu_a     = {1'b0, end_ff};
            alu_b     = {1'b0, start_ff};
            length_in = alu_flag ? '0 : alu_res[ADDR_W-1:0];
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            // frames left up to the limit
            alu_op   = OP_SUB;
            alu_a    = {{PAGE_BITS{1'b0}}, limit_ff};
            alu_b    = {{PAGE_BITS{1'b0}}, cursor_ff};
            rem_in   = alu_res[FW-1:0];
            empty_in = alu_flag || (alu_res[FW-1:0] == '0);
            state_in = ST_FORM;
         end
         ST_FORM: begin
            // load the result once the output register frees, then advance
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (empty_ff) begin
                  has_block_in = 1'b0;
                  frame_in     = '0;
                  order_in     = '0;
                  repeat_in    = '0;
                  freed_in     = '0;
                  last_in      = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  alu_op       = OP_ADD;
                  alu_a        = {{PAGE_BITS{1'b0}}, cursor_ff};
                  alu_b        = {{PAGE_BITS{1'b0}}, step};
                  cursor_in    = alu_res[FW-1:0];
                  has_block_in = 1'b1;
                  frame_in     = frame_ext[FRAME_OUT_W-1:0];
                  order_in     = dec.order;
                  repeat_in    = repeat_ext[REPEAT_W-1:0];
                  freed_in     = dec.last ? length_ff : '0;
                  last_in      = dec.last;
                  state_in     = dec.last ? ST_IDLE : ST_DIFF;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and result payload
   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      end_ff       <= end_in;
      cursor_ff    <= cursor_in;
      limit_ff     <= limit_in;
      length_ff    <= length_in;
      rem_ff       <= rem_in;
      empty_ff     <= empty_in;
      has_block_ff <= has_block_in;
      frame_ff     <= frame_in;
      order_ff     <= order_in;
      repeat_ff    <= repeat_in;
      freed_ff     <= freed_in;
      last_ff      <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_has_block    = has_block_ff;
   assign rsp_block_frame  = frame_ff;
   assign rsp_block_order  = order_ff;
   assign rsp_block_repeat = repeat_ff;
   assign rsp_freed_bytes  = freed_ff;
   assign rsp_last         = last_ff;

   // A block is formed only while frames remain below the limit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FORM && !empty_ff) |-> (rem_ff != '0))
      else $error("block formed with no frames left");

   // The cursor never passes the limit after an advance
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FORM && !empty_ff && out_free) |=> (cursor_ff <= limit_ff))
      else $error("cursor advanced past the limit");

   // An item without a block closes its range
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_block) |-> (rsp_last && rsp_freed_bytes == '0))
      else $error("empty result not marked last");

endmodule
